/* rtl/core/srt_pkg.sv */
// Package for screen_region_table: field widths, stream layout, table entry type
// and the per-axis containment test.
// No dependencies.
package srt_pkg;

    localparam int unsigned MAX_ENTRIES_DEF = 16;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned INDEX_W = 4;
    localparam int unsigned COUNT_W = 5;

    localparam int unsigned S_TDATA_W = 4 * COORD_W;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = 16;

    // result tdata bit positions
    localparam int unsigned M_IDX_LSB   = 0;
    localparam int unsigned M_HIT_BIT   = INDEX_W;
    localparam int unsigned M_DROP_BIT  = INDEX_W + 1;
    localparam int unsigned M_EMPTY_BIT = INDEX_W + 2;
    localparam int unsigned M_CNT_LSB   = INDEX_W + 3;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0]        h;
        logic [COORD_W-1:0]        w;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } entry_t;

    // negative point matches any; else org <= p < org + ext at 18 bits
    function automatic logic axis_holds(logic signed [COORD_W-1:0] p,
                                        logic signed [COORD_W-1:0] org,
                                        logic [COORD_W-1:0] ext);
        logic signed [COORD_W+1:0] p_s;
        logic signed [COORD_W+1:0] lo_s;
        logic signed [COORD_W+1:0] hi_s;
        p_s  = (COORD_W+2)'(p);
        lo_s = (COORD_W+2)'(org);
        hi_s = lo_s + $signed({2'b00, ext});
        return p[COORD_W-1] || ((p_s >= lo_s) && (p_s < hi_s));
    endfunction

endpackage

/* rtl/core/screen_region_table.sv */
// Top level of screen_region_table: rectangle table in one synchronous memory,
// scanned one entry per cycle. Depends on srt_pkg.
//
// The single memory read port delivers one stored rectangle per cycle and the
// read register holds each read ahead of its compare. After the accepting edge
// the block passes through the scan state and then the done state, which loads
// the output register. On an empty table the scan ends at once; otherwise it
// stops at the first match, or, when all entries are read without a match, takes
// a closing step before the done state. A new item is accepted as
// soon as the previous result sits in the output register; a stalled result
// holds the block until it is taken. The table is empty after reset; entries are
// valid below the entry count, so the memory needs no clearing. op travels in
// s_tuser; entry_count is masked to five bits and entry_index to four.
module screen_region_table #(
    parameter int unsigned MAX_ENTRIES = srt_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x[15:0], pos_y[31:16], size_w[47:32], size_h[63:48]
    input  logic [srt_pkg::S_TDATA_W-1:0]   s_tdata,
    // op[0]
    input  logic [srt_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // entry_index[3:0], hit[4], dropped[5], table_empty[6], entry_count[11:7], zero[15:12]
    output logic [srt_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CW    = srt_pkg::COORD_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    srt_pkg::entry_t mem [MAX_ENTRIES];
    srt_pkg::entry_t rd_data_reg;

    logic                    op_reg;
    logic signed [CW-1:0]    px_reg, py_reg;
    logic [CW-1:0]           w_reg, h_reg;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic                    cmp_vld_reg;

    logic [IDX_W-1:0]        res_idx_reg, res_idx_next;
    logic                    res_hit_reg, res_hit_next;
    logic                    res_drop_reg, res_drop_next;
    logic                    res_empty_reg, res_empty_next;

    logic                    m_tvalid_reg;
    logic [srt_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                    match, scan_hit, scan_end, issue, full;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    srt_pkg::entry_t         mem_wdata;
    logic                    accept, out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign full     = (count_reg == CNT_W'(MAX_ENTRIES));

    always_comb begin
        if (op_reg == srt_pkg::OP_ADD) begin
            match = (rd_data_reg.x == px_reg) && (rd_data_reg.y == py_reg);
        end else begin
            match = srt_pkg::axis_holds(px_reg, rd_data_reg.x, rd_data_reg.w) &&
                    srt_pkg::axis_holds(py_reg, rd_data_reg.y, rd_data_reg.h);
        end
    end

    assign scan_hit = (state_reg == ST_SCAN) && cmp_vld_reg && match;
    assign scan_end = (state_reg == ST_SCAN) && !cmp_vld_reg && (scan_idx_reg == count_reg);
    assign issue    = (state_reg == ST_SCAN) && !scan_hit && (scan_idx_reg != count_reg);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        res_idx_next   = res_idx_reg;
        res_hit_next   = res_hit_reg;
        res_drop_next  = res_drop_reg;
        res_empty_next = res_empty_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[IDX_W-1:0];
        mem_wdata.x    = px_reg;
        mem_wdata.y    = py_reg;
        mem_wdata.w    = w_reg;
        mem_wdata.h    = h_reg;
        if (issue) begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next     = ST_SCAN;
                    scan_idx_next  = '0;
                    res_idx_next   = '0;
                    res_hit_next   = 1'b0;
                    res_drop_next  = 1'b0;
                    res_empty_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    state_next   = ST_DONE;
                    res_idx_next = cmp_idx_reg;
                    res_hit_next = 1'b1;
                    if (op_reg == srt_pkg::OP_ADD) begin
                        mem_we      = 1'b1;
                        mem_waddr   = cmp_idx_reg;
                        mem_wdata.w = (w_reg > rd_data_reg.w) ? w_reg : rd_data_reg.w;
                        mem_wdata.h = (h_reg > rd_data_reg.h) ? h_reg : rd_data_reg.h;
                    end
                end else if (scan_end) begin
                    state_next = ST_DONE;
                    if (op_reg == srt_pkg::OP_ADD) begin
                        if (full) begin
                            res_drop_next = 1'b1;
                        end else begin
                            mem_we       = 1'b1;
                            res_idx_next = count_reg[IDX_W-1:0];
                            count_next   = count_reg + CNT_W'(1);
                        end
                    end else begin
                        res_empty_next = (count_reg == '0);
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[srt_pkg::M_IDX_LSB +: srt_pkg::INDEX_W] =
            srt_pkg::INDEX_W'(res_idx_reg);
        m_tdata_next[srt_pkg::M_HIT_BIT]   = res_hit_reg;
        m_tdata_next[srt_pkg::M_DROP_BIT]  = res_drop_reg;
        m_tdata_next[srt_pkg::M_EMPTY_BIT] = res_empty_reg;
        m_tdata_next[srt_pkg::M_CNT_LSB +: srt_pkg::COUNT_W] =
            srt_pkg::COUNT_W'(count_reg);
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            rd_data_reg <= mem[scan_idx_reg[IDX_W-1:0]];
            cmp_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (accept) begin
            op_reg <= s_tuser[0];
            px_reg <= s_tdata[CW-1:0];
            py_reg <= s_tdata[2*CW-1:CW];
            w_reg  <= s_tdata[3*CW-1:2*CW];
            h_reg  <= s_tdata[4*CW-1:3*CW];
        end
        res_idx_reg   <= res_idx_next;
        res_hit_reg   <= res_hit_next;
        res_drop_reg  <= res_drop_next;
        res_empty_reg <= res_empty_next;
        scan_idx_reg  <= scan_idx_next;
        if ((state_reg == ST_DONE) && out_free) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= issue;
            if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/core/srt_checker.sv */
// Port-level checker for screen_region_table and the bind that attaches it.
// Depends on srt_pkg and screen_region_table.
module srt_checker #(
    parameter int unsigned MAX_ENTRIES = srt_pkg::MAX_ENTRIES_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [srt_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                         hit, dropped, empty;
    logic [srt_pkg::INDEX_W-1:0]  idx;
    logic [srt_pkg::COUNT_W-1:0]  cnt;

    assign idx     = m_tdata[srt_pkg::M_IDX_LSB +: srt_pkg::INDEX_W];
    assign hit     = m_tdata[srt_pkg::M_HIT_BIT];
    assign dropped = m_tdata[srt_pkg::M_DROP_BIT];
    assign empty   = m_tdata[srt_pkg::M_EMPTY_BIT];
    assign cnt     = m_tdata[srt_pkg::M_CNT_LSB +: srt_pkg::COUNT_W];

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(cnt) <= MAX_ENTRIES) || (MAX_ENTRIES > 31))
        else $error("entry count above table size");

    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones({hit, dropped, empty}) <= 1)
        else $error("conflicting result flags");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (dropped || empty) |-> (idx == '0) &&
        (!dropped || (32'(cnt) == (MAX_ENTRIES % 32))) && (!empty || (cnt == '0)))
        else $error("drop or empty result inconsistent");

endmodule

bind screen_region_table srt_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_srt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
